### design/lpss_pkg.sv
`default_nettype none

package lpss_pkg;

  localparam int MAX_LEN_DEFAULT = 1024;
  localparam int CHAR_W          = 8;
  localparam int LEN_OUT_W       = 11;

  typedef logic [CHAR_W-1:0]    char_t;
  typedef logic [LEN_OUT_W-1:0] len_out_t;

  // per-cycle control from the sequencer to the compare unit
  typedef struct packed {
    logic valid;       // a span pair is in the compare stage
    logic short_span;  // span length 2 or 3: inner span is trivially a palindrome
    logic bank;        // flag bank of this length's parity
    logic clear;       // new string closed, restart best length
  } cmp_ctl_t;

endpackage

`default_nettype wire

### design/lpss_char_if.sv
`default_nettype none

interface lpss_char_if;
  logic                valid;
  logic                ready;
  lpss_pkg::char_t     char_in;
  logic                last_char;

  modport source (output valid, output char_in, output last_char, input ready);
  modport sink (input valid, input char_in, input last_char, output ready);
endinterface

`default_nettype wire

### design/lpss_result_if.sv
`default_nettype none

interface lpss_result_if;
  logic                 valid;
  logic                 ready;
  lpss_pkg::len_out_t   longest_len;
  logic                 truncated;

  modport source (output valid, output longest_len, output truncated, input ready);
  modport sink (input valid, input longest_len, input truncated, output ready);
endinterface

`default_nettype wire

### design/longest_palindrome_substring_length.sv
`default_nettype none

// Longest palindromic substring length. Characters stream in one word per
// cycle on chars while chars is ready, last_char marking the end of the
// string; up to MAX_LEN are stored, later ones are dropped and the result is
// flagged truncated. After the last character, one compare unit sweeps every
// span, length 2 up to n, one span per cycle, reading both end characters
// from the text store and the inner-span flag from the bank of that length's
// parity. The sweep is followed by a drain state before the result word is
// posted; chars stays not ready from the last character until the result is
// in the output register. The output register lets the next string load
// while a result waits to be taken.
module longest_palindrome_substring_length #(
  parameter int MAX_LEN = lpss_pkg::MAX_LEN_DEFAULT
) (
  input  wire logic     clk,
  input  wire logic     rst,
  lpss_char_if.sink     chars,
  lpss_result_if.source result
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);

  logic               tw_en;
  logic [AW-1:0]      tw_addr;
  lpss_pkg::char_t    tw_data;
  logic [AW-1:0]      rd_addr_a;
  logic [AW-1:0]      rd_addr_b;
  logic [AW-1:0]      rd_flag_addr;
  logic [AW-1:0]      fw_addr;
  logic [CW-1:0]      len1;
  lpss_pkg::cmp_ctl_t ctl;
  lpss_pkg::char_t    ch_a;
  lpss_pkg::char_t    ch_b;
  logic               flag0;
  logic               flag1;
  logic               hit;
  logic [CW-1:0]      best;

  lpss_seq #(
    .MAX_LEN (MAX_LEN),
    .AW      (AW),
    .CW      (CW)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .chars        (chars),
    .result       (result),
    .best         (best),
    .tw_en        (tw_en),
    .tw_addr      (tw_addr),
    .tw_data      (tw_data),
    .rd_addr_a    (rd_addr_a),
    .rd_addr_b    (rd_addr_b),
    .rd_flag_addr (rd_flag_addr),
    .fw_addr      (fw_addr),
    .len1         (len1),
    .ctl          (ctl)
  );

  lpss_text_mem #(
    .DEPTH (MAX_LEN),
    .AW    (AW)
  ) u_text (
    .clk       (clk),
    .wr_en     (tw_en),
    .wr_addr   (tw_addr),
    .wr_data   (tw_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (ch_a),
    .rd_data_b (ch_b)
  );

  // even lengths in bank 0, odd in bank 1: row L overwrites row L-2
  lpss_flag_ram #(
    .DEPTH (MAX_LEN),
    .AW    (AW)
  ) u_flag0 (
    .clk     (clk),
    .wr_en   (ctl.valid & !ctl.bank),
    .wr_addr (fw_addr),
    .wr_data (hit),
    .rd_addr (rd_flag_addr),
    .rd_data (flag0)
  );

  lpss_flag_ram #(
    .DEPTH (MAX_LEN),
    .AW    (AW)
  ) u_flag1 (
    .clk     (clk),
    .wr_en   (ctl.valid & ctl.bank),
    .wr_addr (fw_addr),
    .wr_data (hit),
    .rd_addr (rd_flag_addr),
    .rd_data (flag1)
  );

  lpss_cmp_unit #(
    .CW (CW)
  ) u_cmp (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .len   (len1),
    .ch_a  (ch_a),
    .ch_b  (ch_b),
    .flag0 (flag0),
    .flag1 (flag1),
    .hit   (hit),
    .best  (best)
  );

endmodule

`default_nettype wire

### design/lpss_text_mem.sv
`default_nettype none

module lpss_text_mem #(
  parameter int DEPTH = lpss_pkg::MAX_LEN_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic            clk,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire lpss_pkg::char_t wr_data,
  input  wire logic [AW-1:0]   rd_addr_a,
  input  wire logic [AW-1:0]   rd_addr_b,
  output lpss_pkg::char_t      rd_data_a,
  output lpss_pkg::char_t      rd_data_b
);

  lpss_pkg::char_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

`default_nettype wire

### design/lpss_flag_ram.sv
`default_nettype none

module lpss_flag_ram #(
  parameter int DEPTH = lpss_pkg::MAX_LEN_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic          wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output logic               rd_data
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### design/lpss_cmp_unit.sv
`default_nettype none

module lpss_cmp_unit #(
  parameter int CW = 11
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire lpss_pkg::cmp_ctl_t ctl,
  input  wire logic [CW-1:0]      len,
  input  wire lpss_pkg::char_t    ch_a,
  input  wire lpss_pkg::char_t    ch_b,
  input  wire logic               flag0,
  input  wire logic               flag1,
  output logic                    hit,
  output logic [CW-1:0]           best
);

  logic inner;

  assign inner = ctl.short_span | (ctl.bank ? flag1 : flag0);
  assign hit   = ctl.valid & (ch_a == ch_b) & inner;

  // lengths are swept in ascending order, so the latest hit is the longest
  always_ff @(posedge clk) begin
    if (rst) begin
      best <= CW'(1);
    end else if (ctl.clear) begin
      best <= CW'(1);
    end else if (hit) begin
      best <= len;
    end
  end

  a_hit_loads_len: assert property (@(posedge clk) disable iff (rst)
    hit |=> best == $past(len))
    else $error("best length not taken from hit");

  a_hit_min_len: assert property (@(posedge clk) disable iff (rst)
    hit |-> len >= CW'(2))
    else $error("hit on span shorter than two");

  a_best_monotonic: assert property (@(posedge clk) disable iff (rst)
    !ctl.clear |=> best >= $past(best))
    else $error("best length decreased within a string");

endmodule

`default_nettype wire

### design/lpss_seq.sv
`default_nettype none

module lpss_seq #(
  parameter int MAX_LEN = lpss_pkg::MAX_LEN_DEFAULT,
  parameter int AW      = $clog2(MAX_LEN),
  parameter int CW      = $clog2(MAX_LEN + 1)
) (
  input  wire logic           clk,
  input  wire logic           rst,
  lpss_char_if.sink           chars,
  lpss_result_if.source       result,
  input  wire logic [CW-1:0]  best,
  output logic                tw_en,
  output logic [AW-1:0]       tw_addr,
  output lpss_pkg::char_t     tw_data,
  output logic [AW-1:0]       rd_addr_a,
  output logic [AW-1:0]       rd_addr_b,
  output logic [AW-1:0]       rd_flag_addr,
  output logic [AW-1:0]       fw_addr,
  output logic [CW-1:0]       len1,
  output lpss_pkg::cmp_ctl_t  ctl
);

  localparam logic [1:0] S_LOAD  = 2'd0;
  localparam logic [1:0] S_SWEEP = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]         state;
  logic [CW-1:0]      count;
  logic [CW-1:0]      n;
  logic [CW-1:0]      len;
  logic [AW-1:0]      i;
  logic [AW-1:0]      i1;
  logic               valid1;
  logic               ovf;
  logic               out_valid;
  lpss_pkg::len_out_t out_len;
  logic               out_trunc;

  logic          accept;
  logic          full;
  logic [CW-1:0] n_after;
  logic [CW-1:0] span_end;
  logic          row_end;
  logic          sweep_end;
  logic          out_free;
  logic          out_load;

  assign chars.ready = (state == S_LOAD);
  assign accept      = chars.valid & chars.ready;
  assign full        = (count == CW'(MAX_LEN));
  assign n_after     = full ? count : count + CW'(1);

  assign span_end  = CW'(i) + len;   // one past the span's right end
  assign row_end   = (span_end == n);
  assign sweep_end = row_end & (len == n);
  assign out_free  = !out_valid | result.ready;
  assign out_load  = (state == S_DONE) & out_free;

  assign tw_en        = accept & !full;
  assign tw_addr      = count[AW-1:0];
  assign tw_data      = chars.char_in;
  assign rd_addr_a    = i;
  assign rd_addr_b    = AW'(span_end - CW'(1));
  assign rd_flag_addr = AW'(CW'(i) + CW'(1));
  assign fw_addr      = i1;

  assign ctl.valid      = valid1;
  assign ctl.short_span = (len1 <= CW'(3));
  assign ctl.bank       = len1[0];
  assign ctl.clear      = accept & chars.last_char;

  assign result.valid       = out_valid;
  assign result.longest_len = out_len;
  assign result.truncated   = out_trunc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      count     <= '0;
      ovf       <= 1'b0;
      valid1    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      valid1 <= (state == S_SWEEP);
      unique case (state)
        S_LOAD: begin
          if (accept) begin
            if (full) begin
              ovf <= 1'b1;
            end else begin
              count <= count + CW'(1);
            end
            if (chars.last_char) begin
              n     <= n_after;
              len   <= CW'(2);
              i     <= '0;
              state <= (n_after >= CW'(2)) ? S_SWEEP : S_DRAIN;
            end
          end
        end
        S_SWEEP: begin
          if (sweep_end) begin
            state <= S_DRAIN;
          end else if (row_end) begin
            len <= len + CW'(1);
            i   <= '0;
          end else begin
            i <= i + AW'(1);
          end
        end
        S_DRAIN: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_LOAD;
            count <= '0;
            ovf   <= 1'b0;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    len1 <= len;
    i1   <= i;
    if (out_load) begin
      out_len   <= lpss_pkg::len_out_t'(best);
      out_trunc <= ovf;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_LEN))
    else $error("character count beyond capacity");

  a_span_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP) |-> (span_end <= n && len >= CW'(2)))
    else $error("sweep span outside stored string");

  a_stage_from_sweep: assert property (@(posedge clk) disable iff (rst)
    valid1 |-> $past(state) == S_SWEEP)
    else $error("compare stage loaded outside sweep");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result word raised outside done state");

endmodule

`default_nettype wire

### verif/longest_palindrome_substring_length_tb.sv
`default_nettype none

module longest_palindrome_substring_length_tb;

  localparam int DEPTH = lpss_pkg::MAX_LEN_DEFAULT;
  localparam int unsigned WATCHDOG_LIMIT = 2_100_000;
  localparam int unsigned RANDOM_WORDS = 1700;

  typedef struct {
    lpss_pkg::char_t ch;
    logic            last;
    int unsigned     gap;    // idle cycles after this word is taken
    bit              drain;  // hold this word until all results are back
  } char_word_t;

  typedef struct {
    lpss_pkg::len_out_t longest_len;
    logic               truncated;
  } palin_result_t;

  logic clk;
  logic rst;

  lpss_char_if   chars_if ();
  lpss_result_if res_if ();

  longest_palindrome_substring_length #(
    .MAX_LEN(DEPTH)
  ) u_top (
    .clk   (clk),
    .rst   (rst),
    .chars (chars_if),
    .result(res_if)
  );

  char_word_t    char_backlog[$];
  palin_result_t pending_results[$];

  // predictor state: one string at a time
  lpss_pkg::char_t text_mem[DEPTH];
  int unsigned     stored_cnt;
  bit              overflowed;
  bit              row_m2[DEPTH+1];
  bit              row_m1[DEPTH+1];
  bit              row_cur[DEPTH+1];

  int unsigned words_planned;
  int unsigned words_sent;
  int unsigned mismatch_cnt;
  int unsigned gap_left;
  int unsigned stall_left;
  bit          eager_sink;
  int unsigned idle_cycles;

  always #10 clk = ~clk;

  // interval DP over the stored characters, two rows kept for the shorter spans
  function automatic int unsigned longest_palindrome();
    int unsigned best;
    int unsigned span;
    int unsigned i;
    best = 1;
    for (i = 0; i <= DEPTH; i++) begin
      row_m2[i] = 1'b1;
      row_m1[i] = 1'b1;
    end
    for (span = 2; span <= stored_cnt; span++) begin
      for (i = 0; i + span <= stored_cnt; i++) begin
        row_cur[i] = (text_mem[i] == text_mem[i+span-1]) && row_m2[i+1];
        if (row_cur[i]) best = span;
      end
      row_m2 = row_m1;
      row_m1 = row_cur;
    end
    return best;
  endfunction

  task automatic absorb_char(input lpss_pkg::char_t ch, input logic last);
    palin_result_t r;
    if (stored_cnt < DEPTH) begin
      text_mem[stored_cnt] = ch;
      stored_cnt++;
    end else begin
      overflowed = 1'b1;
    end
    if (last) begin
      r.longest_len = lpss_pkg::len_out_t'(longest_palindrome());
      r.truncated   = overflowed;
      pending_results.push_back(r);
      stored_cnt = 0;
      overflowed = 1'b0;
    end
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return 0;
    else if (r < 95) return $urandom_range(1, 3);
    else return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 16);
    else if (r < 95) return $urandom_range(17, 48);
    else return $urandom_range(49, 100);
  endfunction

  task automatic add_word(input lpss_pkg::char_t ch, input logic last, input bit drain);
    char_word_t w;
    w.ch    = ch;
    w.last  = last;
    w.gap   = pick_gap();
    w.drain = drain;
    char_backlog.push_back(w);
  endtask

  task automatic add_bytes(input lpss_pkg::char_t s[$], input bit burst,
                           input bit drain_first);
    char_word_t w;
    int unsigned k;
    for (k = 0; k < s.size(); k++) begin
      w.ch    = s[k];
      w.last  = (k == s.size() - 1);
      w.gap   = burst ? 0 : pick_gap();
      w.drain = drain_first && (k == 0);
      char_backlog.push_back(w);
    end
  endtask

  // random string: full-range noise, narrow alphabet, planted palindrome,
  // or a palindrome end to end
  task automatic add_random_string(input int unsigned len, input bit drain_first);
    lpss_pkg::char_t s[$];
    int unsigned     kind;
    int unsigned     base;
    int unsigned     width;
    int unsigned     pal_len;
    int unsigned     at;
    int unsigned     k;
    kind  = $urandom_range(0, 3);
    base  = $urandom_range(0, 255);
    width = $urandom_range(1, 3);
    for (k = 0; k < len; k++) begin
      if (kind == 1) s.push_back(lpss_pkg::char_t'(base + $urandom_range(0, width)));
      else s.push_back(lpss_pkg::char_t'($urandom_range(0, 255)));
    end
    if (kind == 2) begin
      pal_len = $urandom_range(1, len);
      at      = $urandom_range(0, len - pal_len);
      for (k = 0; k < pal_len / 2; k++) s[at+pal_len-1-k] = s[at+k];
    end else if (kind == 3) begin
      for (k = 0; k < len / 2; k++) s[len-1-k] = s[k];
    end
    add_bytes(s, $urandom_range(0, 3) == 0, drain_first);
  endtask

  // full store, mirrored so the whole store is one palindrome, then three
  // words past capacity; the marked one is dropped too
  task automatic add_overflow_string();
    lpss_pkg::char_t s[$];
    int              k;
    for (k = 0; k < DEPTH / 2; k++) s.push_back(lpss_pkg::char_t'($urandom_range(0, 255)));
    for (k = DEPTH / 2 - 1; k >= 0; k--) s.push_back(s[k]);
    for (k = 0; k < 3; k++) s.push_back(lpss_pkg::char_t'($urandom_range(0, 255)));
    add_bytes(s, 1'b0, 1'b1);
  endtask

  // sender
  always @(posedge clk) begin
    char_word_t w;
    if (rst) begin
      chars_if.valid     <= 1'b0;
      chars_if.char_in   <= '0;
      chars_if.last_char <= 1'b0;
      gap_left = 0;
    end else begin
      if (chars_if.valid && chars_if.ready) begin
        absorb_char(chars_if.char_in, chars_if.last_char);
        words_sent++;
      end
      if (!chars_if.valid || chars_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          chars_if.valid <= 1'b0;
        end else if (char_backlog.size() > 0 &&
                     !(char_backlog[0].drain && pending_results.size() != 0)) begin
          w = char_backlog.pop_front();
          chars_if.valid     <= 1'b1;
          chars_if.char_in   <= w.ch;
          chars_if.last_char <= w.last;
          gap_left = w.gap;
        end else begin
          chars_if.valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    palin_result_t e;
    if (rst) begin
      res_if.ready <= 1'b0;
      stall_left = 0;
      eager_sink = 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (pending_results.size() == 0) begin
          $error("result word with nothing expected: longest_len %0d truncated %0b",
                 res_if.longest_len, res_if.truncated);
          mismatch_cnt++;
        end else begin
          e = pending_results.pop_front();
          if (res_if.longest_len !== e.longest_len) begin
            $error("longest_len mismatch: expected %0d, actual %0d",
                   e.longest_len, res_if.longest_len);
            mismatch_cnt++;
          end
          if (res_if.truncated !== e.truncated) begin
            $error("truncated mismatch: expected %0b, actual %0b",
                   e.truncated, res_if.truncated);
            mismatch_cnt++;
          end
        end
      end
      if ($urandom_range(0, 299) == 0) eager_sink = ~eager_sink;
      if (eager_sink) begin
        stall_left = 0;
        res_if.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < 70) begin
        res_if.ready <= 1'b1;
      end else begin
        res_if.ready <= 1'b0;
        stall_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 60)
                                                 : $urandom_range(0, 2);
      end
    end
  end

  // watchdog: the long sweep of a full store keeps both sides quiet
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((chars_if.valid && chars_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned     strings;
    lpss_pkg::char_t s[$];
    clk                = 1'b0;
    rst                = 1'b1;
    chars_if.valid     = 1'b0;
    chars_if.char_in   = '0;
    chars_if.last_char = 1'b0;
    res_if.ready       = 1'b0;
    stored_cnt         = 0;
    overflowed         = 1'b0;
    words_sent         = 0;
    mismatch_cnt       = 0;

    // directed: single characters at both extremes, even and odd centers,
    // overlapping palindromes, no palindrome longer than one
    add_word(8'h00, 1'b1, 1'b0);
    add_word(8'hFF, 1'b1, 1'b0);
    s = '{8'hFF, 8'hFF};                      add_bytes(s, 1'b0, 1'b0);
    s = '{8'h00, 8'hFF};                      add_bytes(s, 1'b0, 1'b0);
    s = '{8'h55, 8'hAA, 8'h55};               add_bytes(s, 1'b0, 1'b0);
    s = '{8'hAA, 8'h55, 8'h55, 8'hAA};        add_bytes(s, 1'b1, 1'b0);
    s = '{8'h80, 8'h7F, 8'h80, 8'h7F, 8'h01}; add_bytes(s, 1'b0, 1'b0);
    s = '{8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15};
    add_bytes(s, 1'b0, 1'b0);

    add_overflow_string();

    strings = 0;
    while (char_backlog.size() < RANDOM_WORDS) begin
      add_random_string(pick_len(), strings == 30);
      strings++;
    end
    words_planned = char_backlog.size();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (words_sent < words_planned) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);

    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
